@@ hdl/psog_pkg.sv @@
// Shared types, constants and the arctangent table for the polygon/star outline generator.
package psog_pkg;

    localparam int MAX_POINTS_DEF   = 32;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int SEG_LIMIT        = 64;
    localparam int SEG_W            = 7;
    localparam int ATAN_LEN         = 24;
    localparam int ATAN_IW          = 5;
    localparam int CW               = 34;   // CORDIC working width
    localparam logic [CW-1:0] CORDIC_GAIN = CW'(652032874);

    localparam logic [31:0] ATAN_TURN [ATAN_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81
    };

    // Controller to datapath commands
    typedef struct packed {
        logic load_req;
        logic div_start;
        logic div_take;
        logic cordic_start;
        logic do_mul;
        logic do_sum;
        logic emit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic cordic_done;
        logic first;
        logic last;
        logic out_free;
    } t_sts;

endpackage

@@ hdl/psog_div.sv @@
// Restoring divider: turn / n, one quotient bit per cycle.
module psog_div import psog_pkg::*; #(
    parameter int NW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_star,
    input  logic [NW-1:0] i_n,
    output logic          o_done,
    output logic [31:0]   o_quo,
    output logic [NW-1:0] o_rem
);
    localparam int DW = 33;

    logic [DW-1:0] r_dvd, n_dvd;
    logic [DW-1:0] r_quo, n_quo;
    logic [NW-1:0] r_rem, n_rem;
    logic [5:0]    r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [NW:0]   w_t;

    assign w_t = {r_rem, r_dvd[DW-1]};

    always_comb begin
        n_dvd  = r_dvd;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_dvd  = i_star ? (DW'(1) << 31) : (DW'(1) << 32);
            n_quo  = '0;
            n_rem  = '0;
            n_cnt  = 6'(DW - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_dvd = {r_dvd[DW-2:0], 1'b0};
            if (w_t >= {1'b0, i_n}) begin
                n_rem = NW'(w_t - {1'b0, i_n});
                n_quo = {r_quo[DW-2:0], 1'b1};
            end else begin
                n_rem = w_t[NW-1:0];
                n_quo = {r_quo[DW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo[31:0];
    assign o_rem  = r_rem;
endmodule

@@ hdl/psog_cordic.sv @@
// Iterative CORDIC: cosine and sine of a 32-bit turn fraction in Q30, one step per cycle.
module psog_cordic import psog_pkg::*; #(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_angle,
    output logic               o_done,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);
    localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic signed [CW-1:0] QTR  = CW'(64'sd1073741824);
    localparam logic signed [CW-1:0] HALF = CW'(64'sd2147483648);

    logic signed [CW-1:0] r_x, r_y, r_z, n_x, n_y, n_z;
    logic signed [CW-1:0] w_z0, w_dx, w_dy, w_at, w_xo, w_yo;
    logic [IW-1:0]        r_i, n_i;
    logic                 r_neg, n_neg, r_busy, n_busy, r_done, n_done;

    assign w_z0 = CW'($signed(i_angle));
    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;
    assign w_at = $signed({{(CW-32){1'b0}}, ATAN_TURN[ATAN_IW'(r_i)]});

    always_comb begin
        n_x = r_x; n_y = r_y; n_z = r_z; n_i = r_i;
        n_neg = r_neg; n_busy = r_busy; n_done = 1'b0;
        if (i_start) begin
            // fold into the right half plane
            n_x = $signed(CORDIC_GAIN);
            n_y = '0;
            n_i = '0;
            n_busy = 1'b1;
            if (w_z0 > QTR) begin
                n_z = w_z0 - HALF; n_neg = 1'b1;
            end else if (w_z0 < -QTR) begin
                n_z = w_z0 + HALF; n_neg = 1'b1;
            end else begin
                n_z = w_z0; n_neg = 1'b0;
            end
        end else if (r_busy) begin
            if (!r_z[CW-1]) begin
                n_x = r_x - w_dx; n_y = r_y + w_dy; n_z = r_z - w_at;
            end else begin
                n_x = r_x + w_dx; n_y = r_y - w_dy; n_z = r_z + w_at;
            end
            n_i = r_i + IW'(1);
            if (r_i == IW'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_i <= n_i; r_neg <= n_neg;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign w_xo   = r_neg ? -r_x : r_x;
    assign w_yo   = r_neg ? -r_y : r_y;
    assign o_cos  = w_xo[31:0];
    assign o_sin  = w_yo[31:0];
    assign o_done = r_done;
endmodule

@@ hdl/psog_dp.sv @@
// Datapath: request hold, vertex angle stepping, radius scaling and the output word register.
module psog_dp import psog_pkg::*; #(
    parameter int MAX_POINTS   = MAX_POINTS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    output t_sts         o_sts,
    input  logic         i_req_type,
    input  logic [111:0] i_req_data,
    input  logic         i_out_ready,
    output logic         o_out_valid,
    output logic [87:0]  o_out_data,
    output logic         o_out_last
);
    localparam int NW = $clog2(MAX_POINTS + 1);

    logic                r_star;
    logic signed [15:0]  r_cx, r_cy;
    logic [14:0]         r_ro, r_ri;
    logic [15:0]         r_start;
    logic [23:0]         r_rgb;
    logic [NW-1:0]       r_n, w_n;
    logic [SEG_W-1:0]    r_segs, r_vtx;
    logic [7:0]          w_segs;
    logic [5:0]          w_cnt;
    logic [31:0]         r_q, r_qstep;
    logic [NW-1:0]       r_r, r_rstep;
    logic [NW:0]         w_rsum;
    logic                div_done, cor_done;
    logic [31:0]         div_quo;
    logic [NW-1:0]       div_rem;
    logic signed [31:0]  cor_cos, cor_sin;
    logic signed [47:0]  r_px, r_py;
    logic signed [15:0]  w_rad;
    logic signed [15:0]  r_x_prev, r_y_prev, r_x_cur, r_y_cur;
    logic                r_out_valid;
    logic [87:0]         r_out_data;
    logic                r_out_last;

    assign w_cnt = i_req_data[83:78];
    always_comb begin
        if (w_cnt == '0)
            w_n = NW'(1);
        else if ({1'b0, w_cnt} > 7'(MAX_POINTS))
            w_n = NW'(MAX_POINTS);
        else
            w_n = NW'(w_cnt);
        w_segs = i_req_type ? 8'({w_n, 1'b0}) : 8'(w_n);
        if (w_segs > 8'(SEG_LIMIT))
            w_segs = 8'(SEG_LIMIT);
    end

    psog_div #(.NW(NW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_star(r_star), .i_n(r_n), .o_done(div_done), .o_quo(div_quo), .o_rem(div_rem)
    );

    psog_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.cordic_start),
        .i_angle({r_start, 16'd0} + r_q),
        .o_done(cor_done), .o_cos(cor_cos), .o_sin(cor_sin)
    );

    // star vertices alternate outer and inner radius
    assign w_rad  = $signed({1'b0, (r_star && r_vtx[0]) ? r_ri : r_ro});
    assign w_rsum = {1'b0, r_r} + {1'b0, r_rstep};

    function automatic logic signed [15:0] coord(input logic signed [15:0] c,
                                                 input logic signed [47:0] p);
        logic signed [47:0] rnd;
        logic signed [18:0] s;
        begin
            rnd = p + 48'sd536870912;
            s   = 19'(rnd >>> 30) + 19'(c);
            if (s > 19'sd32767)
                coord = 16'sd32767;
            else if (s < -19'sd32768)
                coord = -16'sd32768;
            else
                coord = s[15:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_star  <= i_req_type;
            r_cx    <= i_req_data[15:0];
            r_cy    <= i_req_data[31:16];
            r_ro    <= i_req_data[46:32];
            r_ri    <= i_req_data[61:47];
            r_start <= i_req_data[77:62];
            r_rgb   <= i_req_data[107:84];
            r_n     <= w_n;
        end
        if (i_cmd.div_take) begin
            r_qstep <= div_quo;
            r_rstep <= div_rem;
            r_q     <= '0;
            r_r     <= '0;
        end
        if (i_cmd.do_mul) begin
            r_px <= 48'(w_rad) * 48'(cor_cos);
            r_py <= 48'(w_rad) * 48'(cor_sin);
        end
        if (i_cmd.do_sum) begin
            r_x_cur <= coord(r_cx, r_px);
            r_y_cur <= coord(r_cy, r_py);
        end
        // advance to the next vertex
        if ((i_cmd.do_sum && r_vtx == '0) || i_cmd.emit) begin
            if (w_rsum >= {1'b0, r_n}) begin
                r_r <= NW'(w_rsum - {1'b0, r_n});
                r_q <= r_q + r_qstep + 32'd1;
            end else begin
                r_r <= w_rsum[NW-1:0];
                r_q <= r_q + r_qstep;
            end
        end
        if (i_cmd.do_sum && r_vtx == '0) begin
            r_x_prev <= coord(r_cx, r_px);
            r_y_prev <= coord(r_cy, r_py);
        end
        if (i_cmd.emit) begin
            r_out_data <= {r_rgb, r_y_cur, r_x_cur, r_y_prev, r_x_prev};
            r_out_last <= (r_vtx == r_segs);
            r_x_prev   <= r_x_cur;
            r_y_prev   <= r_y_cur;
        end
        if (!i_rst_n) begin
            r_segs      <= '0;
            r_vtx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_req) begin
                r_segs <= w_segs[SEG_W-1:0];
                r_vtx  <= '0;
            end else if ((i_cmd.do_sum && r_vtx == '0) || i_cmd.emit) begin
                r_vtx <= r_vtx + SEG_W'(1);
            end
            if (i_cmd.emit)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    assign o_sts.div_done    = div_done;
    assign o_sts.cordic_done = cor_done;
    assign o_sts.first       = (r_vtx == '0);
    assign o_sts.last        = (r_vtx == r_segs);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten");
    // the index steps one past the count on the last word and holds there until the next load
    a_vtx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vtx <= r_segs + SEG_W'(1))
        else $error("vertex index past segment count");
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.emit))
        else $error("output valid without emit");
endmodule

@@ hdl/psog_ctrl.sv @@
// Controller state machine sequencing the divide once per request, then CORDIC, scale and emit per vertex.
module psog_ctrl import psog_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_CST  = 3'd2;
    localparam logic [2:0] S_CWT  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // first cycle here kicks the divider; wait for its done pulse
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state = S_CST;
                end
            end
            S_CST: begin
                o_cmd.cordic_start = 1'b1;
                n_state = S_CWT;
            end
            S_CWT: begin
                if (i_sts.cordic_done)
                    n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.do_mul = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.do_sum = 1'b1;
                n_state = i_sts.first ? S_CST : S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = i_sts.last ? S_IDLE : S_CST;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_one_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.load_req, o_cmd.cordic_start, o_cmd.do_mul, o_cmd.do_sum,
                    o_cmd.emit}) <= 1)
        else $error("conflicting commands");
    a_kick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_req |=> r_state == S_DIV)
        else $error("divider not waited for");
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_sts.last) |=> o_in_ready)
        else $error("not idle after last word");
endmodule

@@ hdl/polygon_star_outline_generator.sv @@
// One request in, its outline out as one word per line segment: n words for a polygon,
// 2n (at most 64) for a star. The divider first sets the vertex angle step, then each
// vertex goes once through the shared iterative CORDIC unit and is scaled by its radius;
// every vertex but the first is then handed to the output register as a segment end.
// A new request is taken once the last word of the previous one sits in the output
// register.
module polygon_star_outline_generator import psog_pkg::*; #(
    parameter int MAX_POINTS   = MAX_POINTS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // center_x, center_y, outer_radius, inner_radius, start_angle, point_count,
    // color_red, color_green, color_blue, zero pad
    input  logic [111:0] s_axis_tdata,
    // req_type
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // seg_x0, seg_y0, seg_x1, seg_y1, out_red, out_green, out_blue
    output logic [87:0]  m_axis_tdata,
    output logic         m_axis_tlast
);
    t_cmd cmd_raw, cmd;
    t_sts sts;
    logic r_kick;

    psog_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready), .i_sts(sts), .o_cmd(cmd_raw)
    );

    // start the divider the cycle after the request lands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_kick <= 1'b0;
        else
            r_kick <= cmd_raw.load_req;
    end
    always_comb begin
        cmd = cmd_raw;
        cmd.div_start = r_kick;
    end

    psog_dp #(.MAX_POINTS(MAX_POINTS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_req_type(s_axis_tuser), .i_req_data(s_axis_tdata),
        .i_out_ready(m_axis_tready), .o_out_valid(m_axis_tvalid),
        .o_out_data(m_axis_tdata), .o_out_last(m_axis_tlast)
    );
endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the polygon/star outline generator.
`timescale 1ns / 1ps

module tb_top import psog_pkg::*; ();

    localparam int HALF_PERIOD = 5;
    localparam int RANDOM_REQS = 360;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_CYCLES = 2000;
    localparam int MAX_SIDES = MAX_POINTS_DEF;
    localparam int MAX_SEGS = SEG_LIMIT;
    localparam int STEPS = CORDIC_STEPS_DEF;

    localparam bit KIND_POLYGON = 1'b0;
    localparam bit KIND_STAR = 1'b1;

    typedef struct {
        bit               kind;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [14:0]      r_out;
        logic [14:0]      r_in;
        logic [15:0]      start;
        logic [5:0]       count;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } shape_req_t;

    typedef struct {
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic             last;
    } segment_t;

    class outline_scoreboard;
        segment_t pending[$];
        int       errors;
        int       checked;
        int       requests;

        function new();
            errors = 0;
            checked = 0;
            requests = 0;
        endfunction

        // cos and sin of a 32-bit turn fraction, Q30
        function void rotate(longint unsigned ang, output longint c, output longint s);
            longint z, x, y, dx, dy;
            bit     flip;
            z = longint'(ang);
            x = 652032874;
            y = 0;
            flip = 0;
            if (z >= 64'sd2147483648) z -= 64'sd4294967296;
            if (z > 64'sd1073741824) begin
                z -= 64'sd2147483648;
                flip = 1;
            end else if (z < -64'sd1073741824) begin
                z += 64'sd2147483648;
                flip = 1;
            end
            for (int i = 0; i < STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
                end else begin
                    x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function logic signed [15:0] place(longint ctr, longint rad, longint trig);
            longint v;
            v = ctr + ((rad * trig + (64'sd1 << 29)) >>> 30);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return 16'(v);
        endfunction

        function void note_request(shape_req_t q);
            longint unsigned n, segs, turn, a0, a1, st;
            longint   c0, s0, c1, s1, r0, r1;
            segment_t sg;
            n = (q.count == 0) ? 1 : q.count;
            if (n > MAX_SIDES) n = MAX_SIDES;
            segs = (q.kind == KIND_STAR) ? 2 * n : n;
            if (segs > MAX_SEGS) segs = MAX_SEGS;
            turn = (q.kind == KIND_STAR) ? 64'd1 << 31 : 64'd1 << 32;
            st = longint'(q.start) << 16;
            requests++;
            for (longint unsigned k = 0; k < segs; k++) begin
                a0 = (st + k * turn / n) & 64'hFFFF_FFFF;
                a1 = (st + (k + 1) * turn / n) & 64'hFFFF_FFFF;
                r0 = q.r_out;
                r1 = q.r_out;
                if (q.kind == KIND_STAR) begin
                    r0 = k[0] ? q.r_in : q.r_out;
                    r1 = k[0] ? q.r_out : q.r_in;
                end
                rotate(a0, c0, s0);
                rotate(a1, c1, s1);
                sg.x0 = place(q.cx, r0, c0);
                sg.y0 = place(q.cy, r0, s0);
                sg.x1 = place(q.cx, r1, c1);
                sg.y1 = place(q.cy, r1, s1);
                sg.red = q.red;
                sg.green = q.green;
                sg.blue = q.blue;
                sg.last = (k + 1 == segs);
                pending.push_back(sg);
            end
        endfunction

        function void compare(string fname, longint e, longint a);
            if (e != a) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, e, a);
            end
        endfunction

        function void check_segment(segment_t act);
            segment_t exp;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected segment word, expected none, got x0=%0d y0=%0d",
                         $time, act.x0, act.y0);
                return;
            end
            exp = pending.pop_front();
            compare("seg_x0", exp.x0, act.x0);
            compare("seg_y0", exp.y0, act.y0);
            compare("seg_x1", exp.x1, act.x1);
            compare("seg_y1", exp.y1, act.y1);
            compare("out_red", exp.red, act.red);
            compare("out_green", exp.green, act.green);
            compare("out_blue", exp.blue, act.blue);
            compare("last_segment", exp.last, act.last);
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [87:0]  m_axis_tdata;
    logic         m_axis_tlast;

    outline_scoreboard sb;
    bit sender_no_gaps;
    bit sink_no_stalls;
    bit hold_sink;

    polygon_star_outline_generator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    initial begin
        #200ms;
        $display("Timeout with %0d segment words outstanding", sb.pending.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
        return $urandom_range(10, 60);
    endfunction

    // Send one request word, waiting out a random gap first unless gaps are switched off.
    task automatic send_request(shape_req_t q);
        int gap;
        gap = sender_no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= q.kind;
        s_axis_tdata <= {4'b0, q.blue, q.green, q.red, q.count, q.start,
                         q.r_in, q.r_out, q.cy, q.cx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(q);
    endtask

    task automatic send_shape(bit kind, int cx, int cy, int ro, int ri, int st, int cnt,
                              int r, int g, int b);
        shape_req_t q;
        q.kind = kind;
        q.cx = 16'(cx);
        q.cy = 16'(cy);
        q.r_out = 15'(ro);
        q.r_in = 15'(ri);
        q.start = 16'(st);
        q.count = 6'(cnt);
        q.red = 8'(r);
        q.green = 8'(g);
        q.blue = 8'(b);
        send_request(q);
    endtask

    // Result side: random stalls unless switched off, one long hold-off on request.
    initial begin
        int stall;
        segment_t act;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                act.x0 = m_axis_tdata[15:0];
                act.y0 = m_axis_tdata[31:16];
                act.x1 = m_axis_tdata[47:32];
                act.y1 = m_axis_tdata[63:48];
                act.red = m_axis_tdata[71:64];
                act.green = m_axis_tdata[79:72];
                act.blue = m_axis_tdata[87:80];
                act.last = m_axis_tlast;
                sb.check_segment(act);
            end
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_sink = 0;
                m_axis_tready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!sink_no_stalls && $urandom_range(0, 5) == 0) stall = pick_gap();
            end
        end
    end

    initial begin
        int cnt;
        sb = new();
        sender_no_gaps = 0;
        sink_no_stalls = 0;
        hold_sink = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = 1'b0;
        s_axis_tdata = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: counts at the edges, saturation, color and angle extremes
        send_shape(KIND_POLYGON, 0, 0, 1600, 0, 0, 4, 0, 0, 0);
        send_shape(KIND_POLYGON, 100, -100, 800, 0, 16'hFFFF, 0, 255, 255, 255);
        send_shape(KIND_POLYGON, -5, 7, 32767, 32767, 0, 1, 1, 2, 3);
        send_shape(KIND_POLYGON, 0, 0, 500, 0, 16'h4000, 2, 170, 85, 15);
        send_shape(KIND_POLYGON, 0, 0, 32767, 0, 16'h8000, 3, 9, 9, 9);
        send_shape(KIND_POLYGON, 1000, 1000, 1000, 0, 123, 32, 7, 8, 9);
        send_shape(KIND_POLYGON, 0, 0, 300, 0, 0, 33, 10, 20, 30);
        send_shape(KIND_POLYGON, 0, 0, 300, 0, 0, 63, 40, 50, 60);
        send_shape(KIND_STAR, 0, 0, 2000, 800, 0, 5, 255, 0, 0);
        send_shape(KIND_STAR, 0, 0, 2000, 32767, 16'hC000, 0, 0, 255, 0);
        send_shape(KIND_STAR, 0, 0, 32767, 0, 16'hFFFF, 32, 0, 0, 255);
        send_shape(KIND_STAR, 0, 0, 1200, 600, 77, 63, 1, 1, 1);
        send_shape(KIND_POLYGON, 32767, 32767, 32767, 0, 0, 8, 3, 3, 3);
        send_shape(KIND_POLYGON, -32768, -32768, 32767, 0, 16'h2000, 8, 4, 4, 4);
        send_shape(KIND_STAR, 32767, -32768, 32767, 32767, 16'h1234, 6, 5, 5, 5);
        send_shape(KIND_STAR, -32768, 32767, 0, 0, 0, 3, 6, 6, 6);
        send_shape(KIND_POLYGON, 0, 0, 0, 32767, 0, 7, 255, 0, 255);
        send_shape(KIND_STAR, 0, 0, 1, 1, 1, 2, 0, 255, 255);

        // back-to-back offers against a blocked output fill the block up
        hold_sink = 1;
        sender_no_gaps = 1;
        for (int i = 0; i < 6; i++)
            send_shape($urandom_range(0, 1), $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 32767), $urandom_range(0, 32767),
                       $urandom_range(0, 65535), $urandom_range(1, 6),
                       $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        sender_no_gaps = 0;

        for (int i = 0; i < RANDOM_REQS; i++) begin
            // alternate stretches with and without idling
            if (i % 60 == 0) begin
                sender_no_gaps = (i % 120 == 60);
                sink_no_stalls = (i % 120 == 60);
            end
            if ($urandom_range(0, 19) == 0) cnt = $urandom_range(0, 63);
            else cnt = $urandom_range(1, 8);
            send_shape($urandom_range(0, 1), $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 1) ? $urandom_range(0, 32767) : $urandom_range(0, 4000),
                       $urandom_range(0, 1) ? $urandom_range(0, 32767) : $urandom_range(0, 4000),
                       $urandom_range(0, 65535), cnt,
                       $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        end
        s_axis_tvalid <= 1'b0;
        sink_no_stalls = 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d polygon and star requests, %0d segment words checked.",
                 sb.requests, sb.checked);
        $display("Included count edges, coordinate saturation and a long output hold-off.");
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
